>>> design/rdq_pkg.sv
`timescale 1ns / 1ps

package rdq_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int DATA_W    = 32;
	localparam int FUNC_W    = 3;
	localparam int STATUS_W  = 2;
	localparam int POS_W     = 6;

	// operation codes
	localparam logic [FUNC_W-1:0] OP_PUSH   = 3'd0;
	localparam logic [FUNC_W-1:0] OP_POP    = 3'd1;
	localparam logic [FUNC_W-1:0] OP_PEEK   = 3'd2;
	localparam logic [FUNC_W-1:0] OP_SEARCH = 3'd3;
	localparam logic [FUNC_W-1:0] OP_CLEAR  = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic                     at_rear;
		logic signed [DATA_W-1:0] value;
	} rdq_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [DATA_W-1:0] data;
		logic [POS_W-1:0]         position;
		logic [POS_W-1:0]         count;
	} rdq_rsp_t;

endpackage

>>> design/rdq_ram.sv
`timescale 1ns / 1ps

module rdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/ring_deque_with_overwrite_core.sv
`timescale 1ns / 1ps
// channel  | signals                   | beat
// ---------+---------------------------+------------------------------------------
// req      | req_valid req_stall req   | one operation: func, at_rear, value
// rsp      | rsp_valid rsp_stall rsp   | one result: status, data, position, count
//
// push and clear go straight to the done state; pop and peek take one registered ring read first, unless empty
// search stops at the first match or after the last entry, skipping the walk when empty: the single
// ring read port and one equality compare walk the entries from the front, one per cycle
// arst_n resets pointers, count and control; ring contents need no clear
// req_stall is high while an operation is in flight; a finished result waits
// in the done state until the output register is free, so rsp_stall backs up

module ring_deque_with_overwrite_core #(
	parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  rdq_pkg::rdq_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rdq_pkg::rdq_rsp_t rsp
);

	import rdq_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_SRCH = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;

	logic [PW-1:0] front_q;
	logic [PW-1:0] rear_q;
	logic [CW-1:0] held_q;
	logic [CW-1:0] held_next;

	rdq_rsp_t res_q;
	rdq_rsp_t out_q;
	logic     out_valid_q;

	logic signed [DATA_W-1:0] key_q;
	logic [PW-1:0]            scan_q;
	logic [CW-1:0]            cmp_pos_q;

	logic              ram_we;
	logic [PW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [PW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	logic accept;
	logic empty;
	logic full;
	logic hit;
	logic last;
	logic slot_free;

	function automatic logic [PW-1:0] slot_next(input logic [PW-1:0] s);
		return (s == PW'(DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [PW-1:0] slot_prev(input logic [PW-1:0] s);
		return (s == '0) ? PW'(DEPTH - 1) : s - 1'b1;
	endfunction

	// count and position are reported modulo the field width
	function automatic logic [POS_W-1:0] fit_pos(input logic [CW-1:0] v);
		logic [CW+POS_W-1:0] w;
		w = {{POS_W{1'b0}}, v};
		return w[POS_W-1:0];
	endfunction

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign empty     = (held_q == '0);
	assign full      = (held_q == CW'(DEPTH - 2));
	assign hit       = ($signed(ram_rdata) == key_q);
	assign last      = (cmp_pos_q == held_q);
	assign slot_free = !out_valid_q || !rsp_stall;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// count after the operation taken this cycle
	always_comb begin
		held_next = held_q;
		case (req.func)
			OP_PUSH: begin
				if (!full) begin
					held_next = held_q + 1'b1;
				end
			end
			OP_POP: begin
				if (!empty) begin
					held_next = held_q - 1'b1;
				end
			end
			OP_CLEAR: held_next = '0;
			default: held_next = held_q;
		endcase
	end

	// ring port steering: writes only on push, reads on accept or while scanning
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = front_q;
		ram_wdata = DATA_W'(req.value);
		ram_raddr = scan_q;
		if (accept) begin
			case (req.func)
				OP_PUSH: begin
					ram_we    = 1'b1;
					ram_waddr = req.at_rear ? rear_q : front_q;
				end
				OP_POP:    ram_raddr = req.at_rear ? slot_prev(rear_q) : slot_next(front_q);
				OP_PEEK:   ram_raddr = slot_next(front_q);
				OP_SEARCH: ram_raddr = slot_next(front_q);
				default:   ram_raddr = scan_q;
			endcase
		end
	end

	rdq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// sequencer, pointers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			rear_q      <= PW'(1);
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						held_q  <= held_next;
						state_q <= S_DONE;
						case (req.func)
							OP_PUSH: begin
								if (!req.at_rear) begin
									front_q <= slot_prev(front_q);
									// overwrite on full: drop the rear value
									if (slot_prev(front_q) == rear_q) begin
										rear_q <= slot_prev(rear_q);
									end
								end else begin
									rear_q <= slot_next(rear_q);
									// overwrite on full: drop the front value
									if (slot_next(rear_q) == front_q) begin
										front_q <= slot_next(front_q);
									end
								end
							end
							OP_POP: begin
								if (!empty) begin
									state_q <= S_READ;
									if (req.at_rear) begin
										rear_q <= slot_prev(rear_q);
									end else begin
										front_q <= slot_next(front_q);
									end
								end
							end
							OP_PEEK: begin
								if (!empty) begin
									state_q <= S_READ;
								end
							end
							OP_SEARCH: begin
								if (!empty) begin
									state_q <= S_SRCH;
								end
							end
							OP_CLEAR: begin
								front_q <= '0;
								rear_q  <= PW'(1);
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_READ: state_q <= S_DONE;
				S_SRCH: begin
					if (hit || last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result, search key and scan position
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_q.status   <= ST_OK;
					res_q.data     <= '0;
					res_q.position <= '0;
					res_q.count    <= fit_pos(held_next);
					case (req.func)
						OP_POP, OP_PEEK: begin
							if (empty) begin
								res_q.status <= ST_EMPTY;
							end
						end
						OP_SEARCH: begin
							res_q.status <= ST_NOT_FOUND;
							key_q        <= req.value;
							scan_q       <= slot_next(slot_next(front_q));
							cmp_pos_q    <= CW'(1);
						end
						default: res_q.status <= ST_OK;
					endcase
				end
			end
			S_READ: res_q.data <= $signed(ram_rdata);
			S_SRCH: begin
				if (hit) begin
					res_q.status   <= ST_OK;
					res_q.position <= fit_pos(cmp_pos_q);
				end else if (!last) begin
					cmp_pos_q <= cmp_pos_q + 1'b1;
					scan_q    <= slot_next(scan_q);
				end
			end
			S_DONE: begin
				if (slot_free) begin
					out_q <= res_q;
				end
			end
			default: res_q <= res_q;
		endcase
	end

	// every accepted operation takes the sequencer out of idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted operation did not start");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(held_q) <= DEPTH - 2)
		else $error("held count above capacity");

	// pointer gap always matches the count
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		((int'(rear_q) > int'(front_q)) ?
			(int'(rear_q) - int'(front_q) - 1) :
			(int'(rear_q) + DEPTH - int'(front_q) - 1)) == int'(held_q))
		else $error("pointers disagree with count");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |-> ((cmp_pos_q != '0) && (cmp_pos_q <= held_q)))
		else $error("search position outside stored range");

	// a finished result is held while the output register is busy
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && out_valid_q && rsp_stall) |=>
			((state_q == S_DONE) && $stable(res_q)))
		else $error("pending result lost");

endmodule
